// ----- design/mrca_pkg.sv -----
// mrca_pkg: shared types, constants and the ordered double compare
// for the row/column argmax/argmin block; no dependencies
`default_nettype none
package mrca_pkg;
	localparam int MAX_VECTOR_DEF = 64;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

	typedef struct packed {
		logic        seed;
		logic        done;
		logic        last;
		logic        err;
		logic [15:0] idx;
		logic [15:0] pos;
	} ctl_t;

	function automatic logic is_nan(input logic [63:0] a);
		return (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
	endfunction

	// ordered a < b, false on nan, +0 == -0
	function automatic logic dbl_lt(input logic [63:0] a, input logic [63:0] b);
		logic az;
		logic r;
		az = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
		if (is_nan(a) || is_nan(b) || az) r = 1'b0;
		else if (a[63] != b[63]) r = a[63];
		else if (a[63]) r = a[62:0] > b[62:0];
		else r = a[62:0] < b[62:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- design/matrix_row_column_argmax_argmin.sv -----
// Streaming argmax/argmin over matrix rows or columns.
// Input channel: value, one matrix element per beat (valid/stall), in
// memory order for the configured layout. Output channel: one beat per
// finished row or column with best_value, best_index, result_position,
// last (final result of the matrix) and error (too many strided entries).
// Config: cfg_we/cfg_index/cfg_data, write only while idle; any write to
// registers 0 to 4 restarts the matrix at row 0, column 0.
// Pipeline: the accepting edge loads the input register (_s1) and the running
// table read; the compare/update and the output register load happen when _s1
// advances, and out_valid then rises only for a finished row or column.
// Throughput: one element per cycle while the output is not stalled; the
// running table forwards its own write to the next element of the same entry.
// Stall: in_stall is asserted only while both stages are full and the output
// is stalled; results are held unchanged until taken.
// Reset: clears config to 1x1 row-major max and counters to zero; the
// running table needs no clearing since each entry is seeded before reading.
// depends on mrca_pkg, mrca_seq
`default_nettype none
module matrix_row_column_argmax_argmin #(
	parameter int MAX_VECTOR = mrca_pkg::MAX_VECTOR_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mrca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                     cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [63:0]                     value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [63:0]                          best_value,
	output logic [15:0]                          best_index,
	output logic [15:0]                          result_position,
	output logic                                 last,
	output logic                                 error
);
	import mrca_pkg::*;
	localparam int SW = (MAX_VECTOR > 1) ? $clog2(MAX_VECTOR) : 1;

	ctl_t ctl, ctl_s1;
	logic [SW-1:0] slot, slot_s1;
	logic direction, v_s1, adv1, acc_in, take, wr_en, byp_s1;
	logic [63:0] value_s1, cur_v, new_v, rd_v_s1, byp_v_s1;
	logic [15:0] cur_i, new_i, rd_i_s1, byp_i_s1;
	logic [63:0] run_v [MAX_VECTOR];
	logic [15:0] run_i [MAX_VECTOR];

	assign adv1 = !out_valid || !out_stall;
	assign in_stall = v_s1 && !adv1;
	assign acc_in = in_valid && !in_stall;
	assign wr_en = v_s1 && adv1 && !ctl_s1.err;

	mrca_seq #(.MAX_VECTOR(MAX_VECTOR), .SW(SW)) u_seq (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.step(acc_in), .ctl, .slot, .direction
	);

	// table read is registered; a write to the same entry on the read edge is forwarded
	assign cur_v = byp_s1 ? byp_v_s1 : rd_v_s1;
	assign cur_i = byp_s1 ? byp_i_s1 : rd_i_s1;
	assign take = direction ? dbl_lt(value_s1, cur_v) : dbl_lt(cur_v, value_s1);

	always_comb begin
		if (ctl_s1.seed) begin
			new_v = value_s1;
			new_i = '0;
		end else if (take) begin
			new_v = value_s1;
			new_i = ctl_s1.idx;
		end else begin
			new_v = cur_v;
			new_i = cur_i;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			value_s1 <= value;
			ctl_s1 <= ctl;
			slot_s1 <= slot;
			rd_v_s1 <= run_v[slot];
			rd_i_s1 <= run_i[slot];
			byp_s1 <= wr_en && (slot_s1 == slot);
			byp_v_s1 <= new_v;
			byp_i_s1 <= new_i;
		end
		if (wr_en) begin
			run_v[slot_s1] <= new_v;
			run_i[slot_s1] <= new_i;
		end
		if (v_s1 && adv1) begin
			best_value <= ctl_s1.err ? 64'd0 : new_v;
			best_index <= ctl_s1.err ? 16'd0 : new_i;
			result_position <= ctl_s1.pos;
			last <= ctl_s1.last;
			error <= ctl_s1.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv1) out_valid <= v_s1 && ctl_s1.done;
			if (acc_in) v_s1 <= 1'b1;
			else if (adv1) v_s1 <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- design/mrca_seq.sv -----
// mrca_seq: row/column position sequencer and config registers
// depends on mrca_pkg
`default_nettype none
module mrca_seq #(
	parameter int MAX_VECTOR = mrca_pkg::MAX_VECTOR_DEF,
	parameter int SW = (MAX_VECTOR > 1) ? $clog2(MAX_VECTOR) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mrca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                     cfg_data,
	input  wire logic                            step,
	output mrca_pkg::ctl_t                       ctl,
	output logic [SW-1:0]                        slot,
	output logic                                 direction
);
	import mrca_pkg::*;

	logic [15:0] num_rows_q, num_cols_q, row_q, col_q, nr, nc, i, j;
	logic layout_q, axis_q, dir_q, strided;
	logic [16:0] count;

	assign nr = (num_rows_q == 16'd0) ? 16'd1 : num_rows_q;
	assign nc = (num_cols_q == 16'd0) ? 16'd1 : num_cols_q;
	assign i = (row_q >= nr) ? 16'd0 : row_q;
	assign j = (col_q >= nc) ? 16'd0 : col_q;
	assign strided = (layout_q == axis_q);
	assign count = strided ? {1'b0, (axis_q ? nr : nc)} : 17'd1;
	assign direction = dir_q;

	always_comb begin
		ctl.pos = axis_q ? i : j;
		ctl.idx = axis_q ? j : i;
		ctl.seed = (ctl.idx == 16'd0);
		ctl.err = count > 17'(MAX_VECTOR);
		ctl.done = axis_q ? (j == nc - 16'd1) : (i == nr - 16'd1);
		ctl.last = (i == nr - 16'd1) && (j == nc - 16'd1);
		slot = strided ? ctl.pos[SW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= 16'd1;
			num_cols_q <= 16'd1;
			layout_q <= 1'b0;
			axis_q <= 1'b0;
			dir_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data;
				REG_NUM_COLS: num_cols_q <= cfg_data;
				REG_LAYOUT: layout_q <= cfg_data[0];
				REG_AXIS: axis_q <= cfg_data[0];
				REG_DIRECTION: dir_q <= cfg_data[0];
				default: ;
			endcase
			if (cfg_index <= REG_DIRECTION) begin
				row_q <= '0;
				col_q <= '0;
			end
		end else if (step) begin
			if (!layout_q) begin
				if (j == nc - 16'd1) begin
					col_q <= '0;
					row_q <= (i == nr - 16'd1) ? 16'd0 : i + 16'd1;
				end else begin
					col_q <= j + 16'd1;
					row_q <= i;
				end
			end else begin
				if (i == nr - 16'd1) begin
					row_q <= '0;
					col_q <= (j == nc - 16'd1) ? 16'd0 : j + 16'd1;
				end else begin
					row_q <= i + 16'd1;
					col_q <= j;
				end
			end
		end
	end
endmodule
`default_nettype wire
